/* hw/rtl/apld_pkg.sv */
// ----------------------------------------------------------------------------
// apld_pkg
// Shared types and constants for the AS path loop detector: request and
// response payloads, the control word broadcast to the cell chain and the
// chain status returned to the control logic.
// ----------------------------------------------------------------------------
package apld_pkg;

   // reserved 4-byte transition AS number
   localparam logic [31:0] TRANSIT_ASN = 32'd23456;

   // one hop of a path
   typedef struct packed {
      logic [31:0] as_number;
      logic        last_hop;
   } req_type;

   // verdict for a finished path
   typedef struct packed {
      logic loop_found;
      logic overflow;
   } rsp_type;

   // control broadcast to every cell of the chain
   typedef struct packed {
      logic update;  // a hop was accepted, recompute hit flags
      logic shift;   // store the hop: every entry moves one cell along
      logic clear;   // end of path: drop all entries and hits
      logic check;   // hop qualifies for a loop compare
   } cell_ctrl_type;

   // chain status back to the control logic
   typedef struct packed {
      logic head_valid;  // at least one hop stored
      logic full;        // every cell holds a hop
      logic any_hit;     // previous hop matched an older entry
   } chain_stat_type;

endpackage

/* hw/rtl/apld_cell.sv */
// ----------------------------------------------------------------------------
// apld_cell
// One storage cell of the path chain. Holds one stored AS number, takes its
// neighbor's entry on a shift and compares its entry against the incoming
// hop, keeping the outcome as a hit flag until the next hop.
// ----------------------------------------------------------------------------
module apld_cell
   import apld_pkg::*;
#(
   parameter bit CHECK_EN = 1'b1
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic [31:0]   query,
   input  logic          prev_valid,
   input  logic [31:0]   prev_data,
   output logic          valid,
   output logic [31:0]   data,
   output logic          hit
);

   logic        valid_ff, valid_in;
   logic [31:0] data_ff, data_in;
   logic        hit_ff, hit_in;

   // entry occupancy
   always_comb begin
      valid_in = valid_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = prev_valid;
      end
   end

   // stored hop moves along on a shift
   assign data_in = ctrl.shift ? prev_data : data_ff;

   // compare against the entry held before this hop is stored
   always_comb begin
      hit_in = hit_ff;
      if (ctrl.clear) begin
         hit_in = 1'b0;
      end else if (ctrl.update) begin
         hit_in = CHECK_EN & ctrl.check & valid_ff & (data_ff == query);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         hit_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         hit_ff   <= hit_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;
   assign hit   = hit_ff;

endmodule

/* hw/rtl/apld_chain.sv */
// ----------------------------------------------------------------------------
// apld_chain
// Row of path cells. The newest hop enters cell 0 and older hops move one
// cell further on each stored hop, so cell k holds the hop k+1 positions
// back. Cells two and beyond are far enough back to count as a loop.
// ----------------------------------------------------------------------------
module apld_chain
   import apld_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  cell_ctrl_type  ctrl,
   input  logic [31:0]    query,
   output logic [31:0]    head_data,
   output chain_stat_type stat
);

   logic [DEPTH-1:0] valid_w;
   logic [DEPTH-1:0] hit_w;
   logic [31:0]      data_w [DEPTH];

   // cell 0 loads the incoming hop
   apld_cell #(
      .CHECK_EN (1'b0)
   ) u_cell_head (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .query      (query),
      .prev_valid (1'b1),
      .prev_data  (query),
      .valid      (valid_w[0]),
      .data       (data_w[0]),
      .hit        (hit_w[0])
   );

   // remaining cells take their neighbor's entry
   for (genvar k = 1; k < DEPTH; k++) begin : g_cell
      apld_cell #(
         .CHECK_EN (k >= 2)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .query      (query),
         .prev_valid (valid_w[k-1]),
         .prev_data  (data_w[k-1]),
         .valid      (valid_w[k]),
         .data       (data_w[k]),
         .hit        (hit_w[k])
      );
   end

   // status toward the control logic
   assign head_data       = data_w[0];
   assign stat.head_valid = valid_w[0];
   assign stat.full       = valid_w[DEPTH-1];
   assign stat.any_hit    = |hit_w;

endmodule

/* hw/rtl/as_path_loop_detect_unit.sv */
// ----------------------------------------------------------------------------
// as_path_loop_detect_unit
// AS path loop detector: takes one AS number per request and gives a verdict
// after the request marked as the last hop of the path.
// ----------------------------------------------------------------------------
// One request is accepted per clock cycle; the verdict appears on the
// response channel in the cycle after the last hop is accepted. Requests stall
// only while a verdict waits unread. Hops are held in a chain of MAX_PATH
// cells, each with its own 32-bit comparator, so every stored hop but the two
// newest is checked against the new one in the cycle it arrives; the outcome
// is counted when the following hop shows the checked one was not the last.
// Hops beyond MAX_PATH are not stored and set the overflow flag of the verdict.
module as_path_loop_detect_unit
   import apld_pkg::*;
#(
   parameter int MAX_PATH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cell_ctrl_type  ctrl;
   chain_stat_type stat;
   logic [31:0]    head_data;
   logic           req_fire;
   logic           path_end;
   logic           loop_seen_ff, loop_seen_in;
   logic           overflow_seen_ff, overflow_seen_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_payload_ff, rsp_payload_in;

   // accept while the response slot is free or being emptied
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign path_end  = req_fire & req_payload.last_hop;

   // chain control: prepending, transition AS and overflow hops are not checked
   always_comb begin
      ctrl.update = req_fire;
      ctrl.shift  = req_fire & ~stat.full;
      ctrl.clear  = path_end;
      ctrl.check  = ~stat.full
                  & (~stat.head_valid | (req_payload.as_number != head_data))
                  & (req_payload.as_number != TRANSIT_ASN);
   end

   apld_chain #(
      .DEPTH (MAX_PATH)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .query     (req_payload.as_number),
      .head_data (head_data),
      .stat      (stat)
   );

   // previous hop's hit counts now that another hop followed
   assign loop_seen_in     = loop_seen_ff | stat.any_hit;
   assign overflow_seen_in = overflow_seen_ff | stat.full;

   // response register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (path_end) begin
         rsp_valid_in              = 1'b1;
         rsp_payload_in.loop_found = loop_seen_in;
         rsp_payload_in.overflow   = overflow_seen_in;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_seen_ff     <= 1'b0;
         overflow_seen_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (path_end) begin
            loop_seen_ff     <= 1'b0;
            overflow_seen_ff <= 1'b0;
         end else if (req_fire) begin
            loop_seen_ff     <= loop_seen_in;
            overflow_seen_ff <= overflow_seen_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // a finished path always yields a verdict next cycle
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      path_end |=> rsp_valid)
      else $error("no verdict after last hop");

   // a new verdict only follows a last hop
   a_verdict_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(path_end))
      else $error("verdict without last hop");

   // chain is empty after a path ends
   a_chain_cleared: assert property (@(posedge clock) disable iff (reset)
      path_end |=> (!stat.head_valid && !stat.any_hit))
      else $error("chain not cleared at end of path");

   // overflow can only be flagged with a full chain
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow_seen_ff |-> stat.full)
      else $error("overflow flagged with room left");

   // an unread verdict is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_fire)
      else $error("request accepted over unread verdict");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for as_path_loop_detect_unit. Paths of AS numbers are
// sent hop by hop over the request channel while a behavioral predictor
// tracks the stored hops and the pending/loop/overflow flags; every verdict
// on the response channel is compared with the oldest predicted one.
// Covers short paths, loops, prepending, the transition AS, store overflow,
// a long response stall and random paths with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench
   import apld_pkg::*;
;

   localparam int PATH_DEPTH = 64;
   localparam int LONG_STALL = 400;
   localparam int RANDOM_ITEMS = 430;
   localparam int QUIET_ITEMS = 50;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   // predictor state
   logic [31:0] hop_store [0:PATH_DEPTH-1];
   int          hops_held = 0;
   logic        loop_flag = 1'b0;
   logic        hit_pending = 1'b0;
   logic        overflow_flag = 1'b0;
   rsp_type     verdict_queue [$];

   int   fail_count = 0;
   int   hops_sent = 0;
   int   paths_done = 0;
   int   loop_paths = 0;
   int   overflow_paths = 0;
   logic quiet = 1'b0;
   logic long_stall_pending = 1'b0;

   as_path_loop_detect_unit #(.MAX_PATH(PATH_DEPTH)) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #1 clock = ~clock;

   // predict the effect of one accepted hop
   task automatic predict_verdict(input logic [31:0] as_num, input logic last);
      int      pos;
      logic    hit;
      rsp_type verdict;
      pos = hops_held;
      hit = 1'b0;
      // a further hop confirms the previous hop's match
      if (hit_pending) loop_flag = 1'b1;
      if (pos < PATH_DEPTH) begin
         if (pos >= 2 && as_num != hop_store[pos-1] && as_num != TRANSIT_ASN) begin
            for (int j = 0; j + 3 <= pos; j++) begin
               if (hop_store[j] == as_num) hit = 1'b1;
            end
         end
         hop_store[pos] = as_num;
         hops_held = pos + 1;
      end else begin
         overflow_flag = 1'b1;
      end
      hit_pending = hit;
      if (last) begin
         verdict.loop_found = loop_flag;
         verdict.overflow   = overflow_flag;
         verdict_queue.push_back(verdict);
         paths_done++;
         if (loop_flag) loop_paths++;
         if (overflow_flag) overflow_paths++;
         hops_held = 0;
         loop_flag = 1'b0;
         hit_pending = 1'b0;
         overflow_flag = 1'b0;
      end
   endtask

   // offer one hop, with an occasional idle burst first
   task automatic send_hop(input logic [31:0] as_num, input logic last);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.as_number <= as_num;
      req_payload.last_hop <= last;
      do @(posedge clock); while (!req_ready);
      hops_sent++;
      predict_verdict(as_num, last);
   endtask

   // send the first len of up to five hops as one path
   task automatic send_seq(input int len, input logic [31:0] a0, a1, a2, a3, a4);
      logic [31:0] hops [0:4];
      hops[0] = a0; hops[1] = a1; hops[2] = a2; hops[3] = a3; hops[4] = a4;
      for (int k = 0; k < len; k++) send_hop(hops[k], k == len - 1);
   endtask

   // one-, two- and three-hop paths never loop
   task automatic test_short_paths();
      send_seq(1, 32'h0, 0, 0, 0, 0);
      send_seq(2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
      send_seq(3, 32'd1, 32'd2, 32'd1, 0, 0);
   endtask

   // loop counted only when the looping hop is not the final one
   task automatic test_loop_detection();
      send_seq(5, 32'd10, 32'd20, 32'd30, 32'd10, 32'd40);
      send_seq(4, 32'd10, 32'd20, 32'd30, 32'd10, 0);
   endtask

   // prepending and transition AS hops are not checked
   task automatic test_prepend_and_trans();
      send_seq(5, 32'd7, 32'd8, 32'd7, 32'd7, 32'd4);
      send_seq(5, TRANSIT_ASN, 32'd2, 32'd3, TRANSIT_ASN, 32'd5);
   endtask

   // paths at and beyond the store depth
   task automatic test_path_overflow();
      // exactly full, looping hop is the last one
      for (int k = 0; k < PATH_DEPTH; k++)
         send_hop(k == PATH_DEPTH - 1 ? 32'hA000_0000 : 32'hA000_0000 + k,
                  k == PATH_DEPTH - 1);
      // last stored hop loops, confirmed by an overflow hop
      for (int k = 0; k < PATH_DEPTH + 2; k++)
         send_hop(k == PATH_DEPTH - 1 ? 32'hB000_0000 : 32'hB000_0000 + k,
                  k == PATH_DEPTH + 1);
      // long loop-free path
      for (int k = 0; k < PATH_DEPTH + 6; k++)
         send_hop(32'hC000_0000 + k, k == PATH_DEPTH + 5);
   endtask

   // receiver holds off while short paths keep coming
   task automatic test_backpressure();
      long_stall_pending = 1'b1;
      for (int p = 0; p < 30; p++) begin
         if (p % 2 == 0) send_hop($urandom, 1'b1);
         else send_seq(2, $urandom, $urandom, 0, 0, 0);
      end
   endtask

   // random paths, mostly short over a small pool of AS numbers
   task automatic test_random_paths();
      logic [31:0] as_pool [0:7];
      logic [31:0] as_num;
      logic [31:0] prev_as;
      int          start_count;
      int          len;
      int          pick;
      logic        noise;
      start_count = hops_sent;
      prev_as = '0;
      while (hops_sent - start_count < RANDOM_ITEMS + QUIET_ITEMS) begin
         if (hops_sent - start_count >= RANDOM_ITEMS) quiet = 1'b1;
         for (int k = 0; k < 8; k++) as_pool[k] = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            as_pool[0] = 32'h0;
            as_pool[1] = 32'hFFFF_FFFF;
         end
         noise = ($urandom_range(0, 9) == 0);
         len = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70)
                                           : $urandom_range(1, 16);
         for (int k = 0; k < len; k++) begin
            pick = $urandom_range(0, 15);
            if (k > 0 && pick < 2) as_num = prev_as;
            else if (pick == 2) as_num = TRANSIT_ASN;
            else if (noise) as_num = $urandom;
            else as_num = as_pool[$urandom_range(0, 5)];
            send_hop(as_num, k == len - 1);
            prev_as = as_num;
         end
      end
   endtask

   // response ready: random stalls, one long hold on request
   initial begin : rsp_ready_driver
      forever begin
         @(posedge clock);
         if (long_stall_pending) begin
            long_stall_pending = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && !reset && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare each accepted verdict with the oldest prediction
   always @(posedge clock) begin : verdict_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (verdict_queue.size() == 0) begin
            $error("verdict with none predicted: loop_found=%0b overflow=%0b",
                   rsp_payload.loop_found, rsp_payload.overflow);
            fail_count++;
         end else begin
            want = verdict_queue.pop_front();
            if (rsp_payload.loop_found !== want.loop_found) begin
               $error("loop_found: expected %0b, actual %0b", want.loop_found,
                      rsp_payload.loop_found);
               fail_count++;
            end
            if (rsp_payload.overflow !== want.overflow) begin
               $error("overflow: expected %0b, actual %0b", want.overflow,
                      rsp_payload.overflow);
               fail_count++;
            end
         end
      end
   end

   // overall time limit
   initial begin : watchdog
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin : main_sequence
      int drain_cycles;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_paths();
      test_loop_detection();
      test_prepend_and_trans();
      test_path_overflow();
      test_backpressure();
      test_random_paths();
      req_valid <= 1'b0;
      // wait for outstanding verdicts
      drain_cycles = 0;
      while (verdict_queue.size() != 0 && drain_cycles < 10000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (verdict_queue.size() != 0) begin
         $error("%0d predicted verdicts never arrived", verdict_queue.size());
         fail_count++;
      end
      $display("sent %0d hops in %0d paths: %0d with loops, %0d overflowed",
               hops_sent, paths_done, loop_paths, overflow_paths);
      $display("mismatches and protocol errors: %0d", fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/apld_pkg.sv
hw/rtl/apld_cell.sv
hw/rtl/apld_chain.sv
hw/rtl/as_path_loop_detect_unit.sv
tb/testbench.sv
